// ----- hw/rtl/fjp_pkg.sv -----
package fjp_pkg;

  // Result kinds on the output channel
  typedef enum logic [2:0] {
    KIND_KEY_CHAR = 3'd0,
    KIND_STR_CHAR = 3'd1,
    KIND_STR_END  = 3'd2,
    KIND_INT      = 3'd3,
    KIND_ACCEPT   = 3'd4,
    KIND_REJECT   = 3'd5
  } kind_e;

  localparam int unsigned FJP_INT_W   = 30;
  localparam int unsigned FJP_Q_DEPTH = 4;
  localparam int unsigned FJP_Q_PTR_W = 2;

  // One result beat
  typedef struct packed {
    kind_e                  kind;
    logic [3:0]             pair_index;
    logic [7:0]             char_value;
    logic [FJP_INT_W-1:0]   int_value;
    logic [4:0]             pair_count;
    logic                   end_of_message;
  } res_t;

  // One queue entry: the results caused by one input byte
  typedef struct packed {
    logic second;
    res_t r0;
    res_t r1;
  } ent_t;

endpackage

// ----- hw/rtl/fjp_front.sv -----
module fjp_front
  import fjp_pkg::*;
#(
  parameter int unsigned MAX_PAIRS = 16,
  parameter int unsigned KEY_CAP   = 16,
  parameter int unsigned VALUE_CAP = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       push_o,
  output ent_t       ent_o
);

  localparam int unsigned CapMax = (KEY_CAP > VALUE_CAP) ? KEY_CAP : VALUE_CAP;
  localparam int unsigned LenW   = $clog2(CapMax);
  localparam int unsigned PcW    = $clog2(MAX_PAIRS + 1);

  typedef enum logic [3:0] {
    PH_OPEN    = 4'd0,
    PH_FIRST   = 4'd1,
    PH_KEY     = 4'd2,
    PH_COLON   = 4'd3,
    PH_VALUE   = 4'd4,
    PH_SVAL    = 4'd5,
    PH_INT     = 4'd6,
    PH_AFTER   = 4'd7,
    PH_NEXTKEY = 4'd8,
    PH_TAIL    = 4'd9
  } phase_e;

  phase_e               phase_q, phase_d;
  logic                 rej_q, rej_d;
  logic [PcW-1:0]       pc_q, pc_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [3:0]           dig_q, dig_d;
  logic [FJP_INT_W-1:0] acc_q, acc_d;

  logic                 val_vld, eom_vld;
  res_t                 val_res, eom_res;
  logic [PcW+3:0]       pc_ext, pc_d_ext;
  logic [PcW-1:0]       pc_inc;
  logic [PcW-1:0]       pc_d_pre;
  logic                 b_ws, b_dig, b_id;
  logic                 av_rej;
  phase_e               av_phase;
  logic [FJP_INT_W-1:0] acc_mul;

  // Classify the byte
  always_comb begin
    b_ws  = (data_byte_i == 8'h20) || (data_byte_i == 8'h09) ||
            (data_byte_i == 8'h0d) || (data_byte_i == 8'h0a);
    b_dig = (data_byte_i >= 8'h30) && (data_byte_i <= 8'h39);
    b_id  = b_dig || ((data_byte_i >= 8'h61) && (data_byte_i <= 8'h7a)) ||
            ((data_byte_i >= 8'h41) && (data_byte_i <= 8'h5a)) ||
            (data_byte_i == 8'h5f) || (data_byte_i == 8'h2d);
  end

  assign pc_inc  = pc_q + PcW'(1);
  assign pc_ext  = {4'b0, pc_q};
  assign acc_mul = (acc_q << 3) + (acc_q << 1) + FJP_INT_W'(data_byte_i[3:0]);

  // Token after a value; the count includes the finished value
  always_comb begin
    av_rej   = 1'b0;
    av_phase = PH_AFTER;
    if (b_ws) begin
      av_phase = PH_AFTER;
    end else if (data_byte_i == 8'h2c) begin
      if (phase_q == PH_INT) begin
        if (pc_inc >= PcW'(MAX_PAIRS)) av_rej = 1'b1;
        else av_phase = PH_NEXTKEY;
      end else begin
        if (pc_q >= PcW'(MAX_PAIRS)) av_rej = 1'b1;
        else av_phase = PH_NEXTKEY;
      end
    end else if (data_byte_i == 8'h7d) begin
      av_phase = PH_TAIL;
    end else begin
      av_rej = 1'b1;
    end
  end

  // Parse one byte
  always_comb begin
    phase_d = phase_q;
    rej_d   = rej_q;
    pc_d    = pc_q;
    len_d   = len_q;
    dig_d   = dig_q;
    acc_d   = acc_q;
    val_vld = 1'b0;
    val_res = '0;
    val_res.pair_index = pc_ext[3:0];
    if (!rej_q) begin
      case (phase_q)
        PH_OPEN: begin
          if (data_byte_i == 8'h7b) phase_d = PH_FIRST;
          else if (!b_ws) rej_d = 1'b1;
        end
        PH_FIRST: begin
          if (data_byte_i == 8'h7d) phase_d = PH_TAIL;
          else if (data_byte_i == 8'h22) begin
            len_d   = '0;
            phase_d = PH_KEY;
          end else if (!b_ws) rej_d = 1'b1;
        end
        PH_NEXTKEY: begin
          if (data_byte_i == 8'h22) begin
            len_d   = '0;
            phase_d = PH_KEY;
          end else if (!b_ws) rej_d = 1'b1;
        end
        PH_KEY: begin
          if (data_byte_i == 8'h22) begin
            if (len_q == '0) rej_d = 1'b1;
            else phase_d = PH_COLON;
          end else if (b_id && (len_q < LenW'(KEY_CAP - 1))) begin
            val_vld            = 1'b1;
            val_res.kind       = KIND_KEY_CHAR;
            val_res.char_value = data_byte_i;
            len_d              = len_q + LenW'(1);
          end else rej_d = 1'b1;
        end
        PH_COLON: begin
          if (data_byte_i == 8'h3a) phase_d = PH_VALUE;
          else if (!b_ws) rej_d = 1'b1;
        end
        PH_VALUE: begin
          if (data_byte_i == 8'h22) begin
            len_d   = '0;
            phase_d = PH_SVAL;
          end else if (b_dig) begin
            acc_d   = FJP_INT_W'(data_byte_i[3:0]);
            dig_d   = 4'd1;
            phase_d = PH_INT;
          end else if (!b_ws) rej_d = 1'b1;
        end
        PH_SVAL: begin
          if (data_byte_i == 8'h22) begin
            val_vld      = 1'b1;
            val_res.kind = KIND_STR_END;
            pc_d         = pc_inc;
            phase_d      = PH_AFTER;
          end else if (b_id && (len_q < LenW'(VALUE_CAP - 1))) begin
            val_vld            = 1'b1;
            val_res.kind       = KIND_STR_CHAR;
            val_res.char_value = data_byte_i;
            len_d              = len_q + LenW'(1);
          end else rej_d = 1'b1;
        end
        PH_INT: begin
          if (b_dig) begin
            if (dig_q >= 4'd9) rej_d = 1'b1;
            else begin
              acc_d = acc_mul;
              dig_d = dig_q + 4'd1;
            end
          end else begin
            val_vld           = 1'b1;
            val_res.kind      = KIND_INT;
            val_res.int_value = acc_q;
            pc_d              = pc_inc;
            phase_d           = av_phase;
            rej_d             = av_rej;
          end
        end
        PH_AFTER: begin
          phase_d = av_phase;
          rej_d   = av_rej;
        end
        PH_TAIL: begin
          if (!b_ws) rej_d = 1'b1;
        end
        default: rej_d = 1'b1;
      endcase
    end

    // Close the message on the final byte
    eom_vld = final_byte_i;
    eom_res = '0;
    eom_res.end_of_message = 1'b1;
    if (!rej_d && (phase_d == PH_TAIL)) begin
      eom_res.kind       = KIND_ACCEPT;
      eom_res.pair_count = pc_d_ext[4:0];
    end else begin
      eom_res.kind = KIND_REJECT;
    end
    if (final_byte_i) begin
      phase_d = PH_OPEN;
      rej_d   = 1'b0;
      pc_d    = '0;
      len_d   = '0;
      dig_d   = '0;
      acc_d   = '0;
    end
  end

  assign pc_d_ext = {4'b0, pc_d_pre};

  // Pair count as it stands before the end-of-message clear
  always_comb begin
    pc_d_pre = pc_q;
    if (!rej_q && ((phase_q == PH_SVAL && data_byte_i == 8'h22) ||
                   (phase_q == PH_INT && !b_dig))) begin
      pc_d_pre = pc_inc;
    end
  end

  // Pack the entry for the queue
  always_comb begin
    ent_o        = '0;
    ent_o.second = val_vld && eom_vld;
    ent_o.r0     = val_vld ? val_res : eom_res;
    ent_o.r1     = eom_res;
    push_o       = accept_i && (val_vld || eom_vld);
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPEN;
      rej_q   <= 1'b0;
      pc_q    <= '0;
      len_q   <= '0;
      dig_q   <= '0;
      acc_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      rej_q   <= rej_d;
      pc_q    <= pc_d;
      len_q   <= len_d;
      dig_q   <= dig_d;
      acc_q   <= acc_d;
    end
  end

endmodule

// ----- hw/rtl/fjp_queue.sv -----
module fjp_queue
  import fjp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ent_t ent_i,
  input  logic pop_i,
  output logic full_o,
  output logic head_vld_o,
  output ent_t head_o
);

  ent_t                   mem_q [FJP_Q_DEPTH];
  logic [FJP_Q_PTR_W-1:0] wr_q, rd_q;
  logic [FJP_Q_PTR_W:0]   cnt_q;

  assign full_o     = (cnt_q == (FJP_Q_PTR_W + 1)'(FJP_Q_DEPTH));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= ent_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + FJP_Q_PTR_W'(1);
      if (pop_i) rd_q <= rd_q + FJP_Q_PTR_W'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + (FJP_Q_PTR_W + 1)'(1);
      else if (!push_i && pop_i) cnt_q <= cnt_q - (FJP_Q_PTR_W + 1)'(1);
    end
  end

endmodule

// ----- hw/rtl/fjp_back.sv -----
module fjp_back
  import fjp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic head_vld_i,
  input  ent_t head_i,
  output logic pop_o,
  input  logic out_stall_i,
  output logic out_valid_o,
  output res_t out_res_o
);

  logic out_vld_q, out_vld_d;
  logic pend_vld_q, pend_vld_d;
  res_t out_res_q, out_res_d;
  res_t pend_res_q, pend_res_d;
  logic load;

  assign load = !out_vld_q || !out_stall_i;

  // Pick the next beat: a held second result first, then the queue head
  always_comb begin
    pop_o      = 1'b0;
    out_vld_d  = out_vld_q;
    out_res_d  = out_res_q;
    pend_vld_d = pend_vld_q;
    pend_res_d = pend_res_q;
    if (load) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_res_d  = pend_res_q;
        pend_vld_d = 1'b0;
      end else if (head_vld_i) begin
        pop_o      = 1'b1;
        out_vld_d  = 1'b1;
        out_res_d  = head_i.r0;
        pend_vld_d = head_i.second;
        pend_res_d = head_i.r1;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    pend_res_q <= pend_res_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_res_q;

endmodule

// ----- hw/rtl/flat_json_object_parser.sv -----
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_stall_o   data_byte_i, final_byte_i
// out      output     out_valid_o/out_stall_i kind_o, pair_index_o, char_value_o,
//                                           int_value_o, pair_count_o, end_of_message_o
//
// One byte is taken every cycle while the four-entry result queue has room.
// A result passes through its queue entry and then the output register;
// the back end sends one beat per cycle while the output is not stalled, the second result of a byte after the first.
// Reset (rst_ni low, asynchronous) clears parser state, queue and output valid.
// A stall on the output fills the queue, after which the input is stalled.
module flat_json_object_parser
  import fjp_pkg::*;
#(
  parameter int unsigned MAX_PAIRS = 16,
  parameter int unsigned KEY_CAP   = 16,
  parameter int unsigned VALUE_CAP = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  pair_index_o,
  output logic [7:0]  char_value_o,
  output logic [29:0] int_value_o,
  output logic [4:0]  pair_count_o,
  output logic        end_of_message_o
);

  logic accept;
  logic push, pop, full, head_vld;
  ent_t ent, head;
  res_t out_res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  fjp_front #(
    .MAX_PAIRS (MAX_PAIRS),
    .KEY_CAP   (KEY_CAP),
    .VALUE_CAP (VALUE_CAP)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .push_o       (push),
    .ent_o        (ent)
  );

  fjp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .ent_i      (ent),
    .pop_i      (pop),
    .full_o     (full),
    .head_vld_o (head_vld),
    .head_o     (head)
  );

  fjp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_i      (head),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res)
  );

  assign kind_o           = out_res.kind;
  assign pair_index_o     = out_res.pair_index;
  assign char_value_o     = out_res.char_value;
  assign int_value_o      = out_res.int_value;
  assign pair_count_o     = out_res.pair_count;
  assign end_of_message_o = out_res.end_of_message;

endmodule
